/* hdl/pfba_pkg.sv */
// Shared types, constants and helpers for the page frame bitmap allocator.
// No dependencies; imported by every module of the block.
package pfba_pkg;

   localparam int MAP_WORDS_DEF  = 1024;   // default bitmap depth in 32-bit words
   localparam int CSR_W          = 11;     // words_in_use register width
   localparam int CNT_W          = 16;     // word counters, hold up to 65535
   localparam int ENTRY_W        = 32;
   localparam int FRAME_OUT_W    = 15;
   localparam int FRAME_W        = 20;     // frame field of a page entry
   localparam int BIT_W          = 5;      // bit index inside a map word
   localparam int MAP_DATA_W     = 32;

   localparam logic [CSR_W-1:0]      WORDS_RESET = 11'd1024;
   localparam logic [ENTRY_W-1:0]    FLAG_MASK   = 32'h0000_0fff;
   localparam logic [ENTRY_W-1:0]    FLAG_PRESENT = 32'h0000_0001;
   localparam logic [ENTRY_W-1:0]    FLAG_RW     = 32'h0000_0002;
   localparam logic [ENTRY_W-1:0]    FLAG_USER   = 32'h0000_0004;
   localparam logic [MAP_DATA_W-1:0] WORD_FULL   = 32'hffff_ffff;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_FULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_FINISH
   } state_type;

   // One finished result beat handed from the controller to the output register.
   typedef struct packed {
      logic [ENTRY_W-1:0]     new_entry;
      logic [FRAME_OUT_W-1:0] frame_number;
      status_type             status;
   } result_type;

   // Index of the lowest clear bit; only meaningful when the word is not full.
   function automatic logic [BIT_W-1:0] first_zero(input logic [MAP_DATA_W-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = MAP_DATA_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* hdl/pfba_frame_ram.sv */
// Frame bitmap storage: single-port synchronous RAM with a registered read.
// Depends on pfba_pkg for the data width.
module pfba_frame_ram
   import pfba_pkg::*;
#(
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic                                       rd_en,
   input  logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] addr,
   input  logic [MAP_DATA_W-1:0]                      wr_data,
   output logic [MAP_DATA_W-1:0]                      rd_data
);

   logic [MAP_DATA_W-1:0] mem [MAP_WORDS];
   logic [MAP_DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pfba_ctrl.sv */
// Allocator sequencer: clearing pass, first-fit word scan, free read-modify-write.
// Depends on pfba_pkg; drives the pfba_frame_ram port.
module pfba_ctrl
   import pfba_pkg::*;
#(
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   item_valid,
   output logic                   item_stall,
   input  logic                   kind,
   input  logic [ENTRY_W-1:0]     page_entry,
   input  logic                   for_kernel,
   input  logic                   writable,
   input  logic [CNT_W-1:0]       active_words,
   // result out
   output logic                   res_valid,
   input  logic                   res_ready,
   output result_type             res,
   // bitmap memory
   output logic                   mem_wr_en,
   output logic                   mem_rd_en,
   output logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] mem_addr,
   output logic [MAP_DATA_W-1:0]  mem_wr_data,
   input  logic [MAP_DATA_W-1:0]  mem_rd_data
);

   localparam int AW = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam logic [CNT_W-1:0] LAST_WORD = CNT_W'(MAP_WORDS - 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;      // clear pointer / word being read
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               kernel_ff, kernel_in;
   logic               wr_ff, wr_in;
   result_type         res_ff, res_in;

   logic [FRAME_W-1:0] req_frame;
   logic [CNT_W-1:0]   req_word;
   logic [FRAME_W-1:0] held_frame;
   logic [BIT_W-1:0]   zero_bit;
   logic [FRAME_W-1:0] found_frame;
   logic [CNT_W-1:0]   next_addr;
   logic [ENTRY_W-1:0] alloc_entry;

   assign req_frame  = page_entry[ENTRY_W-1:ENTRY_W-FRAME_W];
   assign req_word   = CNT_W'(req_frame[FRAME_W-1:BIT_W]);
   assign held_frame = entry_ff[ENTRY_W-1:ENTRY_W-FRAME_W];
   assign zero_bit   = first_zero(mem_rd_data);
   assign found_frame = {addr_ff[FRAME_W-BIT_W-1:0], zero_bit};
   assign next_addr  = addr_ff + CNT_W'(1);

   always_comb begin
      alloc_entry = entry_ff | FLAG_PRESENT;
      if (wr_ff) begin
         alloc_entry = alloc_entry | FLAG_RW;
      end
      if (kernel_ff) begin
         alloc_entry = alloc_entry & ~FLAG_USER;
      end
      alloc_entry = alloc_entry | {found_frame, 12'h000};
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      entry_in    = entry_ff;
      kernel_in   = kernel_ff;
      wr_in       = wr_ff;
      res_in      = res_ff;
      item_stall  = 1'b1;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_addr    = addr_ff[AW-1:0];
      mem_wr_data = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            addr_in   = next_addr;
            if (addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            item_stall = 1'b0;
            if (item_valid) begin
               entry_in  = page_entry;
               kernel_in = for_kernel;
               wr_in     = writable;
               res_in.new_entry    = page_entry;
               res_in.frame_number = '0;
               if (kind == KIND_ALLOC) begin
                  if (req_frame != '0) begin
                     res_in.status = ST_NOCHANGE;
                     state_in      = S_FINISH;
                  end else if (active_words == '0) begin
                     res_in.status = ST_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     mem_rd_en = 1'b1;
                     mem_addr  = '0;
                     addr_in   = '0;
                     state_in  = S_SCAN;
                  end
               end else begin
                  if (req_frame == '0) begin
                     res_in.status = ST_NOCHANGE;
                     state_in      = S_FINISH;
                  end else if (req_word >= active_words) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_FINISH;
                  end else begin
                     mem_rd_en = 1'b1;
                     mem_addr  = req_word[AW-1:0];
                     addr_in   = req_word;
                     state_in  = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            if (mem_rd_data != WORD_FULL) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data | (MAP_DATA_W'(1) << zero_bit);
               res_in.new_entry    = alloc_entry;
               res_in.frame_number = found_frame[FRAME_OUT_W-1:0];
               res_in.status       = ST_DONE;
               state_in = S_FINISH;
            end else if (next_addr < active_words) begin
               mem_rd_en = 1'b1;
               mem_addr  = next_addr[AW-1:0];
               addr_in   = next_addr;
            end else begin
               res_in.status = ST_FULL;
               state_in      = S_FINISH;
            end
         end
         S_FREE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data & ~(MAP_DATA_W'(1) << held_frame[BIT_W-1:0]);
            res_in.new_entry    = entry_ff & FLAG_MASK;
            res_in.frame_number = held_frame[FRAME_OUT_W-1:0];
            res_in.status       = ST_DONE;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      kernel_ff <= kernel_in;
      wr_ff     <= wr_in;
      res_ff    <= res_in;
   end

endmodule

/* hdl/page_frame_bitmap_allocator_unit.sv */
// Page frame bitmap allocator, top level: size register, bitmap RAM, sequencer,
// result output register. Depends on pfba_pkg, pfba_frame_ram and pfba_ctrl.
//
// req_* : one item per beat (kind, page_entry, for_kernel, writable), taken
//         when req_valid is high and req_stall is low.
// rsp_* : one result beat per item (new_entry, frame_number, status), taken
//         when rsp_valid is high and rsp_stall is low.
// csr_* : write of words_in_use when csr_valid and csr_ready are high;
//         csr_ready is always high; write only while no item is in flight.
// Path from the accepting edge to the result beat on rsp_*: no-change,
// out-of-range and empty-range items go straight to the finish state; a free
// reads its map word and writes it back; an allocate reads map words up to the
// first word with a clear bit (one word per cycle, single port), then writes it
// back. One item at a time; the next is taken only after the previous result
// moves to the output register.
// Reset: words_in_use returns to 1024 and the sequencer zeroes all MAP_WORDS
// bitmap words, one word per cycle, with req_stall high; csr writes are taken.
// A stalled result holds in the output register; the sequencer then waits
// with its own finished result and stalls new requests.
module page_frame_bitmap_allocator_unit
   import pfba_pkg::*;
#(
   parameter int MAP_WORDS = MAP_WORDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [ENTRY_W-1:0]     req_page_entry,
   input  logic                   req_for_kernel,
   input  logic                   req_writable,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ENTRY_W-1:0]     rsp_new_entry,
   output logic [FRAME_OUT_W-1:0] rsp_frame_number,
   output logic [1:0]             rsp_status,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_W-1:0]       csr_words_in_use
);

   localparam int AW = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;

   logic [CSR_W-1:0]       words_ff, words_in;
   logic [CNT_W-1:0]       active_words;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   logic                   res_valid;
   logic                   res_ready;
   result_type             res;

   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_addr;
   logic [MAP_DATA_W-1:0]  mem_wr_data;
   logic [MAP_DATA_W-1:0]  mem_rd_data;

   // words_in_use register; values above the map depth saturate
   assign csr_ready = 1'b1;
   assign words_in  = (csr_valid && csr_ready) ? csr_words_in_use : words_ff;
   assign active_words = (CNT_W'(words_ff) > CNT_W'(MAP_WORDS)) ?
                         CNT_W'(MAP_WORDS) : CNT_W'(words_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= WORDS_RESET;
      end else begin
         words_ff <= words_in;
      end
   end

   pfba_frame_ram #(
      .MAP_WORDS (MAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   pfba_ctrl #(
      .MAP_WORDS (MAP_WORDS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_valid),
      .item_stall   (req_stall),
      .kind         (req_kind),
      .page_entry   (req_page_entry),
      .for_kernel   (req_for_kernel),
      .writable     (req_writable),
      .active_words (active_words),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res),
      .mem_wr_en    (mem_wr_en),
      .mem_rd_en    (mem_rd_en),
      .mem_addr     (mem_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_data  (mem_rd_data)
   );

   // output register: loads when empty or when its beat is taken this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_entry    = rsp_ff.new_entry;
   assign rsp_frame_number = rsp_ff.frame_number;
   assign rsp_status       = rsp_ff.status;

endmodule

/* test/page_frame_bitmap_allocator_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for page_frame_bitmap_allocator_unit: allocate/free beats with
// a bit-true frame map predictor, random sender gaps and receiver stalls.
// Depends on pfba_pkg and the allocator RTL.
module page_frame_bitmap_allocator_unit_tb;
   import pfba_pkg::*;

   // one request beat as queued for the driver
   typedef struct packed {
      kind_type             kind;
      logic [ENTRY_W-1:0]   page_entry;
      logic                 for_kernel;
      logic                 writable;
   } page_req_t;

   localparam int FRAMES_PER_WORD = 32;
   localparam int PRINT_CAP       = 40;       // mismatch lines printed before going quiet
   localparam int HOLDOFF_CYCLES  = 300;      // length of each long receiver hold-off
   localparam int DRAIN_CYCLES    = 40;       // quiet time after the last result

   // clock, reset and DUT pins; every input starts at a known value
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_kind = 1'b0;
   logic [ENTRY_W-1:0]     req_page_entry = '0;
   logic                   req_for_kernel = 1'b0;
   logic                   req_writable = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ENTRY_W-1:0]     rsp_new_entry;
   logic [FRAME_OUT_W-1:0] rsp_frame_number;
   logic [1:0]             rsp_status;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_W-1:0]       csr_words_in_use = '0;

   // predictor state: shadow frame map and shadow words_in_use register
   logic [MAP_DATA_W-1:0]  shadow_frame_map [MAP_WORDS_DEF];
   logic [CSR_W-1:0]       shadow_words = WORDS_RESET;

   page_req_t              pending_reqs [$];
   result_type             expected_rsps [$];

   // bookkeeping shared between the driver, monitor, receiver, hold-off and stimulus
   bit                     req_taken = 1'b0;
   bit                     long_hold = 1'b0;
   int                     accepted_count = 0;
   int                     checked_count = 0;
   int                     error_count = 0;
   int                     done_count = 0;
   int                     nochange_count = 0;
   int                     full_count = 0;
   int                     range_count = 0;

   page_frame_bitmap_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_page_entry   (req_page_entry),
      .req_for_kernel   (req_for_kernel),
      .req_writable     (req_writable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_entry    (rsp_new_entry),
      .rsp_frame_number (rsp_frame_number),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_words_in_use (csr_words_in_use)
   );

   always #5 clock = ~clock;

   // Number of frames covered by the shadow register; values above the map
   // depth saturate, zero means no frames at all.
   function automatic int frame_span(input logic [CSR_W-1:0] words);
      return ((words > MAP_WORDS_DEF) ? MAP_WORDS_DEF : int'(words)) * FRAMES_PER_WORD;
   endfunction

   // First-fit allocate / free against the shadow map. Updates the map and
   // returns the result beat the block must produce for this request.
   function automatic result_type predict_page_update(input page_req_t rq);
      result_type       r;
      int               span;
      int               found;
      logic [FRAME_W-1:0] fr;
      span = frame_span(shadow_words);
      found = -1;
      fr = rq.page_entry[ENTRY_W-1:12];
      r.new_entry = rq.page_entry;
      r.frame_number = '0;
      r.status = ST_NOCHANGE;
      if (rq.kind == KIND_ALLOC) begin
         if (fr != '0) begin
            r.status = ST_NOCHANGE;                     // entry already names a frame
         end else begin
            for (int w = 0; w < span / FRAMES_PER_WORD && found < 0; w++) begin
               if (shadow_frame_map[w] != WORD_FULL) begin
                  for (int b = 0; b < FRAMES_PER_WORD && found < 0; b++) begin
                     if (!shadow_frame_map[w][b]) begin
                        found = w * FRAMES_PER_WORD + b;
                     end
                  end
               end
            end
            if (found < 0) begin
               r.status = ST_FULL;
            end else begin
               shadow_frame_map[found / FRAMES_PER_WORD][found % FRAMES_PER_WORD] = 1'b1;
               r.new_entry = rq.page_entry | FLAG_PRESENT;
               if (rq.writable) begin
                  r.new_entry = r.new_entry | FLAG_RW;
               end
               if (rq.for_kernel) begin
                  r.new_entry = r.new_entry & ~FLAG_USER;
               end
               r.new_entry = r.new_entry | (ENTRY_W'(found) << 12);
               r.frame_number = FRAME_OUT_W'(found);
               r.status = ST_DONE;
            end
         end
      end else begin
         if (fr == '0) begin
            r.status = ST_NOCHANGE;                     // frame zero is never freed
         end else if (int'(fr) >= span) begin
            r.status = ST_RANGE;                        // map left alone
         end else begin
            shadow_frame_map[int'(fr) / FRAMES_PER_WORD][int'(fr) % FRAMES_PER_WORD] = 1'b0;
            r.new_entry = rq.page_entry & FLAG_MASK;
            r.frame_number = FRAME_OUT_W'(fr);
            r.status = ST_DONE;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                                  input logic [ENTRY_W-1:0] want);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
      end
   endtask

   // Monitor first, then request acceptance: a spurious result beat is judged
   // against the queue as it stood before this edge's new expectation.
   always @(posedge clock) begin : beat_monitor
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_new_entry, '0);
         end else begin
            want = expected_rsps.pop_front();
            checked_count++;
            if (rsp_new_entry !== want.new_entry) begin
               report_mismatch("new_entry", rsp_new_entry, want.new_entry);
            end
            if (rsp_frame_number !== want.frame_number) begin
               report_mismatch("frame_number", ENTRY_W'(rsp_frame_number),
                               ENTRY_W'(want.frame_number));
            end
            if (rsp_status !== want.status) begin
               report_mismatch("status", ENTRY_W'(rsp_status), ENTRY_W'(want.status));
            end
            case (want.status)
               ST_DONE:     done_count++;
               ST_NOCHANGE: nochange_count++;
               ST_FULL:     full_count++;
               default:     range_count++;
            endcase
         end
      end
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(predict_page_update(pending_reqs.pop_front()));
         req_taken = 1'b1;
         accepted_count++;
      end
   end

   // Sender: bursts of random length separated by random gaps (gap of zero
   // gives back-to-back bursts). A beat stays on the pins until it is taken.
   always @(negedge clock) begin : req_driver
      int burst_left;
      int gap_left;
      if (!reset && !(req_valid && !req_taken)) begin
         if (burst_left <= 0 && gap_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            burst_left--;
            req_valid <= 1'b1;
            req_kind <= pending_reqs[0].kind;
            req_page_entry <= pending_reqs[0].page_entry;
            req_for_kernel <= pending_reqs[0].for_kernel;
            req_writable <= pending_reqs[0].writable;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Receiver: stall pattern switches mode at random between
   // none, light, heavy and alternating; long_hold overrides it.
   always @(negedge clock) begin : rsp_receiver
      int   mode;
      int   mode_left;
      bit   alt;
      logic stall_now;
      if (mode_left <= 0) begin
         mode = $urandom_range(0, 3);
         mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      alt = !alt;
      case (mode)
         0:       stall_now = 1'b0;
         1:       stall_now = ($urandom_range(0, 7) == 0);
         2:       stall_now = ($urandom_range(0, 1) == 1);
         default: stall_now = alt;
      endcase
      rsp_stall <= stall_now || long_hold;
   end

   // Two long hold-offs mid-run: results back up, the output register and
   // the sequencer fill, and req_stall must hold the sender off.
   initial begin : long_holdoff
      for (int n = 0; n < 2; n++) begin
         while (accepted_count < 500 + n * 600) @(posedge clock);
         long_hold = 1'b1;
         repeat (HOLDOFF_CYCLES) @(posedge clock);
         long_hold = 1'b0;
      end
   end

   function automatic void queue_req(input kind_type kind, input logic [ENTRY_W-1:0] entry,
                                     input logic for_kernel, input logic writable);
      page_req_t rq;
      rq.kind = kind;
      rq.page_entry = entry;
      rq.for_kernel = for_kernel;
      rq.writable = writable;
      pending_reqs.push_back(rq);
   endfunction

   // Mostly well-formed traffic: clean allocates (zero frame field) and frees
   // of low frames or frames around the top of the range; the rest is noise.
   function automatic void queue_random_reqs(input int count, input int span);
      int                  pick;
      int                  fr;
      logic [ENTRY_W-1:0]  flags;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         flags = ENTRY_W'($urandom_range(0, 4095));
         if (pick < 55) begin
            queue_req(KIND_ALLOC, flags, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 90) begin
            if (span == 0 || $urandom_range(0, 4) != 0) begin
               fr = $urandom_range(0, ((span < 256) ? span : 256) + 3);
            end else begin
               fr = $urandom_range(span - 2, span + 2);
            end
            queue_req(KIND_FREE, (ENTRY_W'(fr) << 12) | flags,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            queue_req(kind_type'($urandom_range(0, 1)), $urandom,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endfunction

   // Register write; only called with nothing in flight.
   task automatic load_words_in_use(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_words_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_words = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      #1;
   endtask

   // Every beat produces a result, so an empty expectation queue means idle.
   task automatic drain_beats();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int words_seq [7];
      int count_seq [7];
      foreach (shadow_frame_map[i]) shadow_frame_map[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, full map. Written while the block still clears its map.
      load_words_in_use(11'd1024);
      queue_req(KIND_ALLOC, 32'h0000_0000, 1'b0, 1'b0);   // hands out frame zero
      queue_req(KIND_ALLOC, 32'h0000_0fff, 1'b1, 1'b1);   // kernel clears user flag
      queue_req(KIND_ALLOC, 32'h0000_0004, 1'b0, 1'b1);
      queue_req(KIND_ALLOC, 32'h0000_1000, 1'b0, 1'b0);   // already allocated
      queue_req(KIND_ALLOC, 32'hffff_ffff, 1'b1, 1'b1);   // already allocated
      queue_req(KIND_ALLOC, 32'h0000_0ffe, 1'b1, 1'b0);
      queue_req(KIND_FREE,  32'h0000_0fff, 1'b0, 1'b0);   // nothing to free
      queue_req(KIND_FREE,  32'h0000_1abc, 1'b1, 1'b1);   // frees frame 1
      queue_req(KIND_FREE,  32'h0000_1000, 1'b0, 1'b0);   // double free
      queue_req(KIND_ALLOC, 32'h0000_0000, 1'b0, 1'b1);   // frame 1 again
      queue_req(KIND_FREE,  32'h07ff_f000, 1'b0, 1'b0);   // last frame in range
      queue_req(KIND_FREE,  32'h0800_0000, 1'b0, 1'b0);   // first frame past range
      queue_req(KIND_FREE,  32'hffff_f000, 1'b1, 1'b1);   // out of range
      queue_req(KIND_FREE,  32'hffff_ffff, 1'b0, 1'b1);
      queue_req(KIND_ALLOC, 32'h0000_0aaa, 1'b1, 1'b1);
      queue_req(KIND_ALLOC, 32'h0000_0555, 1'b0, 1'b0);
      drain_beats();

      // Zero words: every allocate runs out, every free is out of range.
      load_words_in_use(11'd0);
      queue_req(KIND_ALLOC, 32'h0000_0000, 1'b0, 1'b0);
      queue_req(KIND_ALLOC, 32'h0000_0fff, 1'b1, 1'b1);
      queue_req(KIND_FREE,  32'h0000_1000, 1'b0, 1'b0);
      drain_beats();

      // Register maximum saturates to the map depth.
      load_words_in_use(11'd2047);
      queue_req(KIND_ALLOC, 32'h0000_0000, 1'b1, 1'b0);
      queue_req(KIND_FREE,  32'h07ff_f000, 1'b0, 1'b0);
      queue_req(KIND_FREE,  32'h0800_0000, 1'b0, 1'b0);
      drain_beats();

      // Random phases; the map carries over between settings. Tiny ranges
      // keep the map full so out-of-frames and refills happen often.
      words_seq = '{1, 2, 1024, 3, 2047, 0, 1024};
      count_seq = '{100, 150, 500, 100, 200, 200, 200};
      words_seq[5] = $urandom_range(1, 40);
      for (int p = 0; p < 7; p++) begin
         load_words_in_use(CSR_W'(words_seq[p]));
         queue_random_reqs(count_seq[p], frame_span(CSR_W'(words_seq[p])));
         drain_beats();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run: %0d request beats, %0d results checked, %0d register settings.",
               accepted_count, checked_count, 10);
      $display("Results: %0d done, %0d no change, %0d out of frames, %0d out of range.",
               done_count, nochange_count, full_count, range_count);
      if (error_count == 0) begin
         $display("PASS page_frame_bitmap_allocator_unit");
      end else begin
         $display("FAIL page_frame_bitmap_allocator_unit");
      end
      $finish;
   end

   // Watchdog, far above the slowest legal run (map clear, scans, stalls).
   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d results still expected.", expected_rsps.size());
      $display("FAIL page_frame_bitmap_allocator_unit");
      $finish;
   end

endmodule
